@@ src/ppps_pkg.sv @@
// shared types and constants for the projective pixel sampler
`timescale 1ns / 1ps
package ppps_pkg;

   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;

   localparam int COORD_W    = 32;
   localparam int ADDR_W     = 18;
   localparam int BYTE_W     = 8;
   localparam int PIX_W      = 3 * BYTE_W;
   localparam int DIM_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int FRAC_W     = 16;
   localparam int SUM_W      = 49;

   localparam logic [DIM_W-1:0] IMAGE_DIM_RESET = DIM_W'(512);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW0_LO      = 3'd0,
      REG_ROW0_HI      = 3'd1,
      REG_ROW1_LO      = 3'd2,
      REG_ROW1_HI      = 3'd3,
      REG_ROW2_LO      = 3'd4,
      REG_ROW2_HI      = 3'd5,
      REG_IMAGE_WIDTH  = 3'd6,
      REG_IMAGE_HEIGHT = 3'd7
   } csr_idx_type;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

endpackage

@@ src/ppps_if.sv @@
// request, response and register-write channel interfaces
`timescale 1ns / 1ps
interface ppps_req_if import ppps_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [ADDR_W-1:0]         pixel_addr;
   logic [BYTE_W-1:0]         pixel_blue;
   logic [BYTE_W-1:0]         pixel_green;
   logic [BYTE_W-1:0]         pixel_red;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;

   modport source (output valid, cmd, pixel_addr, pixel_blue, pixel_green, pixel_red,
                   point_x, point_y, point_z, input ready);
   modport sink   (input valid, cmd, pixel_addr, pixel_blue, pixel_green, pixel_red,
                   point_x, point_y, point_z, output ready);
endinterface

interface ppps_rsp_if import ppps_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] red;
   logic [BYTE_W-1:0] green;
   logic [BYTE_W-1:0] blue;
   logic              out_of_range;

   modport source (output valid, red, green, blue, out_of_range, input ready);
   modport sink   (input valid, red, green, blue, out_of_range, output ready);
endinterface

interface ppps_csr_if import ppps_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/projective_point_pixel_sample_core.sv @@
// projective pixel sampler: projection pipeline, divider stages and pixel store
`timescale 1ns / 1ps
// Takes one request per clock unless stalled, and gives one response per sample
// request; pixel writes give none. A sample runs through a 32x32 multiplier
// stage, a sum stage, a magnitude stage, one restoring divider stage per
// quotient bit (QB = clog2(max(MAX_WIDTH, MAX_HEIGHT) + 1), 10 at the defaults),
// an address stage and the pixel store; the store read and the response valid
// are registered together. The pixel store is a single
// port synchronous memory of MAX_WIDTH * MAX_HEIGHT words; writes travel down
// the same pipeline and reach the store in request order, so a sample always
// sees exactly the writes requested before it. Throughput is set by the one
// store port: one request per cycle, writes and samples mixed freely. The
// whole pipeline holds while a response waits on rsp_ch.ready. Quotients at
// or above 2^QB are flagged by one compare before the divider, which is why
// only QB quotient bits are developed. Register writes are accepted every
// cycle and belong in idle periods. The store has no reset; a sample of a
// pixel never written returns undefined colour.
module projective_point_pixel_sample_core import ppps_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input logic        clock,
   input logic        reset,
   ppps_req_if.sink   req_ch,
   ppps_rsp_if.source rsp_ch,
   ppps_csr_if.sink   csr_ch
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int QB     = $clog2(MAXDIM + 1);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int DW     = SUM_W + QB;

   // item payload carried alongside the arithmetic
   typedef struct packed {
      logic              smp;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  pix;
      logic              zero;
      logic              negu;
      logic              negv;
      logic              bigu;
      logic              bigv;
   } item_type;

   // registers
   logic [CSR_DATA_W-1:0] proj_ff [6];
   logic [DIM_W-1:0]      width_ff;
   logic [DIM_W-1:0]      height_ff;

   logic signed [COORD_W-1:0] coef [3][4];
   logic signed [COORD_W-1:0] pt [3];
   logic [WW-1:0]             w_eff;
   logic [HW-1:0]             h_eff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) proj_ff[i] <= '0;
         width_ff  <= IMAGE_DIM_RESET;
         height_ff <= IMAGE_DIM_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_idx_type'(csr_ch.index)) inside
            REG_ROW0_LO, REG_ROW0_HI, REG_ROW1_LO,
            REG_ROW1_HI, REG_ROW2_LO, REG_ROW2_HI: begin
               proj_ff[csr_ch.index] <= csr_ch.data;
            end
            REG_IMAGE_WIDTH: begin
               width_ff <= csr_ch.data[DIM_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               height_ff <= csr_ch.data[DIM_W-1:0];
            end
         endcase
      end
   end

   // coefficient 3 of each row is the translation
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         coef[r][0] = proj_ff[2*r][31:0];
         coef[r][1] = proj_ff[2*r][63:32];
         coef[r][2] = proj_ff[2*r+1][31:0];
         coef[r][3] = proj_ff[2*r+1][63:32];
      end
   end

   assign pt[0] = req_ch.point_x;
   assign pt[1] = req_ch.point_y;
   assign pt[2] = req_ch.point_z;

   // geometry clipped to the store size
   assign w_eff = (32'(width_ff) < 32'(MAX_WIDTH)) ? WW'(width_ff) : WW'(MAX_WIDTH);
   assign h_eff = (32'(height_ff) < 32'(MAX_HEIGHT)) ? HW'(height_ff) : HW'(MAX_HEIGHT);

   // pipeline advance: everything moves unless a response is waiting
   logic out_valid_ff;
   logic adv;

   assign adv          = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // stage 1: products
   logic                     v1_ff;
   item_type                 it1_ff;
   logic signed [PROD_W-1:0] prod1_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it1_ff <= '{smp: (req_ch.cmd == CMD_SAMPLE), addr: req_ch.pixel_addr,
                     pix: {req_ch.pixel_red, req_ch.pixel_green, req_ch.pixel_blue},
                     default: '0};
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               prod1_ff[r][k] <= PROD_W'(coef[r][k]) * PROD_W'(pt[k]);
            end
         end
      end
   end

   // stage 2: floor to q16 and sum with translation
   logic                    v2_ff;
   item_type                it2_ff;
   logic signed [SUM_W-1:0] sum2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it2_ff <= it1_ff;
         for (int r = 0; r < 3; r++) begin
            sum2_ff[r] <= SUM_W'(prod1_ff[r][0] >>> FRAC_W)
                        + SUM_W'(prod1_ff[r][1] >>> FRAC_W)
                        + SUM_W'(prod1_ff[r][2] >>> FRAC_W)
                        + SUM_W'(coef[r][3]);
         end
      end
   end

   // stage 3: magnitudes, signs and range precheck (divider entry)
   logic [SUM_W-1:0] mag [3];
   logic             negu_c;
   logic             negv_c;
   logic             bigu_c;
   logic             bigv_c;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         mag[r] = sum2_ff[r][SUM_W-1] ? (~sum2_ff[r] + SUM_W'(1)) : sum2_ff[r];
      end
      negu_c = sum2_ff[0][SUM_W-1] ^ sum2_ff[2][SUM_W-1];
      negv_c = sum2_ff[1][SUM_W-1] ^ sum2_ff[2][SUM_W-1];
      // quotient of 2^QB or more can never land inside the image
      bigu_c = DW'(mag[0]) >= (DW'(mag[2]) << QB);
      bigv_c = DW'(mag[1]) >= (DW'(mag[2]) << QB);
   end

   logic             dv_ff  [QB+1];
   item_type         dit_ff [QB+1];
   logic [SUM_W-1:0] dz_ff  [QB+1];
   logic [SUM_W-1:0] rem_ff [QB+1][2];
   logic [QB-1:0]    quo_ff [QB+1][2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dit_ff[0]    <= '{smp: it2_ff.smp, addr: it2_ff.addr, pix: it2_ff.pix,
                           zero: (sum2_ff[2] == '0), negu: negu_c, negv: negv_c,
                           bigu: bigu_c, bigv: bigv_c};
         dz_ff[0]     <= mag[2];
         rem_ff[0][0] <= mag[0];
         rem_ff[0][1] <= mag[1];
         quo_ff[0][0] <= '0;
         quo_ff[0][1] <= '0;
      end
   end

   // restoring divider, one quotient bit per stage, x and y lanes side by side
   for (genvar k = 0; k < QB; k++) begin : g_div
      localparam int B = QB - 1 - k;
      logic [DW-1:0] dsh;

      assign dsh = DW'(dz_ff[k]) << B;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dit_ff[k+1] <= dit_ff[k];
            dz_ff[k+1]  <= dz_ff[k];
            for (int l = 0; l < 2; l++) begin
               if (DW'(rem_ff[k][l]) >= dsh) begin
                  rem_ff[k+1][l] <= SUM_W'(DW'(rem_ff[k][l]) - dsh);
                  quo_ff[k+1][l] <= quo_ff[k][l] | (QB'(1) << B);
               end else begin
                  rem_ff[k+1][l] <= rem_ff[k][l];
                  quo_ff[k+1][l] <= quo_ff[k][l];
               end
            end
         end
      end
   end

   // address stage: bounds check and row * width + column
   logic [QB-1:0] qu;
   logic [QB-1:0] qv;
   logic          oku;
   logic          okv;
   logic          flag_c;
   logic [AW-1:0] rd_addr_c;
   logic          wr_ok_c;

   always_comb begin
      qu        = quo_ff[QB][0];
      qv        = quo_ff[QB][1];
      oku       = !dit_ff[QB].bigu && (qu == '0 || !dit_ff[QB].negu)
                  && (32'(qu) < 32'(w_eff));
      okv       = !dit_ff[QB].bigv && (qv == '0 || !dit_ff[QB].negv)
                  && (32'(qv) < 32'(h_eff));
      flag_c    = dit_ff[QB].zero || !oku || !okv;
      rd_addr_c = AW'(32'(qv) * 32'(w_eff) + 32'(qu));
      wr_ok_c   = 32'(dit_ff[QB].addr) < 32'(DEPTH);
   end

   logic             vc_ff;
   logic             smp_c_ff;
   logic             flag_c_ff;
   logic             wr_ok_ff;
   logic [AW-1:0]    mem_addr_ff;
   logic [PIX_W-1:0] wr_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= dv_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         smp_c_ff    <= dit_ff[QB].smp;
         flag_c_ff   <= flag_c;
         wr_ok_ff    <= wr_ok_c;
         wr_pix_ff   <= dit_ff[QB].pix;
         mem_addr_ff <= dit_ff[QB].smp ? rd_addr_c : AW'(dit_ff[QB].addr);
      end
   end

   // pixel store: single port, one write or one read per cycle while not stalled, in request order
   logic [PIX_W-1:0] store_mem [DEPTH];
   logic [PIX_W-1:0] rd_pix_ff;

   always_ff @(posedge clock) begin
      if (adv && vc_ff) begin
         if (!smp_c_ff) begin
            if (wr_ok_ff) begin
               store_mem[mem_addr_ff] <= wr_pix_ff;
            end
         end else begin
            rd_pix_ff <= store_mem[mem_addr_ff];
         end
      end
   end

   // response register
   logic out_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= vc_ff && smp_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_flag_ff <= flag_c_ff;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.out_of_range = out_flag_ff;
   assign rsp_ch.red          = out_flag_ff ? '0 : rd_pix_ff[3*BYTE_W-1:2*BYTE_W];
   assign rsp_ch.green        = out_flag_ff ? '0 : rd_pix_ff[2*BYTE_W-1:BYTE_W];
   assign rsp_ch.blue         = out_flag_ff ? '0 : rd_pix_ff[BYTE_W-1:0];

endmodule

@@ src/ppps_checker.sv @@
// port-level checks for the projective pixel sampler, bound to the top level
`timescale 1ns / 1ps
module ppps_checker import ppps_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] red,
   input logic [BYTE_W-1:0] green,
   input logic [BYTE_W-1:0] blue,
   input logic              out_of_range
);

   // a waiting response keeps offering itself
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // flagged samples carry no colour
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_of_range |-> red == '0 && green == '0 && blue == '0)
      else $error("flagged response with colour");

   // pipeline holds while the response is stalled
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule

bind projective_point_pixel_sample_core ppps_checker u_ppps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .red          (rsp_ch.red),
   .green        (rsp_ch.green),
   .blue         (rsp_ch.blue),
   .out_of_range (rsp_ch.out_of_range)
);
